>>> src/ctcu_pkg.sv
// ----------------------------------------------------------------------------
// ctcu_pkg
// Shared constants, codes and types of the CMAC tile coding unit.
// ----------------------------------------------------------------------------
package ctcu_pkg;

  // default sizes of the stores and loops
  localparam int STORE_DEPTH_C = 4096;
  localparam int MAX_DIMS_C    = 4;
  localparam int MAX_TILINGS_C = 16;
  localparam int MAX_OUTPUTS_C = 8;

  // wide enough for any address the generator can form at the largest sizes
  localparam int ADDR_W = 36;
  // number of coordinate ports
  localparam int NUM_COORDS = 4;
  // width of sums and gradient entries
  localparam int VAL_W = 24;

  // request codes
  typedef enum logic [1:0] {
    REQ_EVAL      = 2'd0,
    REQ_WRITE     = 2'd1,
    REQ_ACCUM     = 2'd2,
    REQ_READCLEAR = 2'd3
  } req_e;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_LOWER    = 3'd0,
    CFG_INV      = 3'd1,
    CFG_TILES    = 3'd2,
    CFG_TILINGS  = 3'd3,
    CFG_DIMS     = 3'd4,
    CFG_OUTPUTS  = 3'd5
  } cfg_idx_e;

  // address generator status toward the controller
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] chstride;
  } ag_t;

endpackage

>>> src/cmac_tile_coding_unit.sv
// ----------------------------------------------------------------------------
// cmac_tile_coding_unit
// CMAC tile coding network in Q8.8: evaluate, weight write, gradient
// accumulate and gradient read-clear over two single-port memories.
// ----------------------------------------------------------------------------
// After reset the block is busy while it zeroes both memories. Items are then
// taken one at a time. Write weight passes through a write state, and
// read-clear through a read state and a write-back state. Evaluate and
// accumulate first run the tiling offset division and stride setup, then
// per tiling the quantization of each dimension; evaluate adds a weight read
// per channel per tiling through the single memory port, and accumulate a
// read-modify-write per tiling. Evaluate ends with one result per cycle, one
// per channel. Results appear for one cycle on result_strobe_o and cannot be
// held off.
// ----------------------------------------------------------------------------
module cmac_tile_coding_unit #(
  parameter int STORE_DEPTH = ctcu_pkg::STORE_DEPTH_C,
  parameter int MAX_DIMS    = ctcu_pkg::MAX_DIMS_C,
  parameter int MAX_TILINGS = ctcu_pkg::MAX_TILINGS_C,
  parameter int MAX_OUTPUTS = ctcu_pkg::MAX_OUTPUTS_C
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic signed [15:0] coord_0_i,
  input  logic signed [15:0] coord_1_i,
  input  logic signed [15:0] coord_2_i,
  input  logic signed [15:0] coord_3_i,
  input  logic [2:0]  channel_select_i,
  input  logic signed [15:0] coefficient_i,
  input  logic [11:0] entry_addr_i,
  input  logic signed [15:0] weight_value_i,
  // result
  output logic        result_strobe_o,
  output logic signed [23:0] result_value_o,
  output logic [2:0]  result_channel_o,
  output logic        last_result_o,
  output logic        addr_overflow_o
);

  localparam int AW  = ctcu_pkg::ADDR_W;
  localparam int VW  = ctcu_pkg::VAL_W;
  localparam int MW  = $clog2(STORE_DEPTH);
  localparam int TLW = $clog2(MAX_TILINGS + 1);
  localparam int DCW = $clog2(MAX_DIMS + 1);
  localparam int OW  = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int OCW = $clog2(MAX_OUTPUTS + 1);

  typedef enum logic [9:0] {
    S_CLEAR  = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_WRITE  = 10'b0000000100,
    S_RC_RD  = 10'b0000001000,
    S_RC_WB  = 10'b0000010000,
    S_WAIT   = 10'b0000100000,
    S_ACC_RD = 10'b0001000000,
    S_ACC_WB = 10'b0010000000,
    S_EV_RD  = 10'b0100000000,
    S_EV_SUM = 10'b1000000000
  } state_e;

  localparam state_e S_EMIT_STATES = S_IDLE;

  state_e state_q, state_d;
  logic   emitting_q, emitting_d;

  // configuration registers
  logic signed [15:0] lower_q;
  logic [15:0]        inv_q;
  logic [6:0]         tiles_q;
  logic [4:0]         tilings_q;
  logic [2:0]         dims_q;
  logic [3:0]         outs_q;

  // clamped configuration
  logic [6:0]     tiles_c;
  logic [TLW-1:0] tl_c;
  logic [DCW-1:0] dims_c;
  logic [OCW-1:0] outs_c;

  // latched request
  ctcu_pkg::req_e     req_q;
  logic signed [15:0] coord_all [ctcu_pkg::NUM_COORDS];
  logic signed [15:0] coord_q [MAX_DIMS];
  logic [2:0]         ch_q;
  logic signed [15:0] coef_q;
  logic [15:0]        wv_q;

  // working registers
  logic [MW-1:0]        clr_q, clr_d;
  logic [AW-1:0]        cur_q, cur_d;
  logic [OW-1:0]        o_q, o_d;
  logic signed [VW-1:0] sum_q [MAX_OUTPUTS];
  logic                 ovf_q [MAX_OUTPUTS];
  logic                 aovf_q;

  logic                 accept;
  logic                 go;
  logic                 adv;
  ctcu_pkg::ag_t        ag;
  logic                 inr;
  logic [MW-1:0]        idx;
  logic                 last_ch;

  // memory ports
  logic                 w_we, g_we;
  logic [MW-1:0]        w_addr, g_addr;
  logic [15:0]          w_wdata, w_rdata;
  logic [VW-1:0]        g_wdata, g_rdata;

  // result word
  logic                 emit;
  logic [VW-1:0]        ev_val;
  logic [2:0]           ev_ch;
  logic                 ev_last, ev_ovf;

  logic signed [VW:0]   gsum;
  logic [VW-1:0]        gsat;
  logic [AW-1:0]        ch_off;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != S_EMIT_STATES) || emitting_q;

  assign coord_all[0] = coord_0_i;
  assign coord_all[1] = coord_1_i;
  assign coord_all[2] = coord_2_i;
  assign coord_all[3] = coord_3_i;

  // clamp the configuration to its legal ranges
  always_comb begin
    if (tiles_q < 7'd2) begin
      tiles_c = 7'd2;
    end else if (tiles_q > 7'd64) begin
      tiles_c = 7'd64;
    end else begin
      tiles_c = tiles_q;
    end
    if (tilings_q == '0) begin
      tl_c = TLW'(1);
    end else if (7'(tilings_q) > 7'(MAX_TILINGS)) begin
      tl_c = TLW'(MAX_TILINGS);
    end else begin
      tl_c = TLW'(tilings_q);
    end
    if (dims_q == '0) begin
      dims_c = DCW'(1);
    end else if (4'(dims_q) > 4'(MAX_DIMS)) begin
      dims_c = DCW'(MAX_DIMS);
    end else begin
      dims_c = DCW'(dims_q);
    end
    if (outs_q == '0) begin
      outs_c = OCW'(1);
    end else if (5'(outs_q) > 5'(MAX_OUTPUTS)) begin
      outs_c = OCW'(MAX_OUTPUTS);
    end else begin
      outs_c = OCW'(outs_q);
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q   <= '0;
      inv_q     <= 16'd256;
      tiles_q   <= 7'd8;
      tilings_q <= 5'd4;
      dims_q    <= 3'd2;
      outs_q    <= 4'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ctcu_pkg::cfg_idx_e'(cfg_index_i))
        ctcu_pkg::CFG_LOWER:   lower_q   <= cfg_data_i;
        ctcu_pkg::CFG_INV:     inv_q     <= cfg_data_i;
        ctcu_pkg::CFG_TILES:   tiles_q   <= cfg_data_i[6:0];
        ctcu_pkg::CFG_TILINGS: tilings_q <= cfg_data_i[4:0];
        ctcu_pkg::CFG_DIMS:    dims_q    <= cfg_data_i[2:0];
        ctcu_pkg::CFG_OUTPUTS: outs_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // address generator and memories
  assign go = accept && ((req_type_i == ctcu_pkg::REQ_EVAL) ||
                         (req_type_i == ctcu_pkg::REQ_ACCUM));

  ctcu_addr_gen #(
    .MAX_DIMS    (MAX_DIMS),
    .MAX_TILINGS (MAX_TILINGS)
  ) u_addr_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .adv_i     (adv),
    .coord_i   (coord_q),
    .lower_i   (lower_q),
    .inv_i     (inv_q),
    .tiles_i   (tiles_c),
    .tilings_i (tl_c),
    .dims_i    (dims_c),
    .ag_o      (ag)
  );

  ctcu_store #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .w_we_i    (w_we),
    .w_addr_i  (w_addr),
    .w_wdata_i (w_wdata),
    .w_rdata_o (w_rdata),
    .g_we_i    (g_we),
    .g_addr_i  (g_addr),
    .g_wdata_i (g_wdata),
    .g_rdata_o (g_rdata)
  );

  assign inr     = (cur_q < AW'(STORE_DEPTH));
  assign idx     = cur_q[MW-1:0];
  assign last_ch = (OCW'(o_q) == outs_c - OCW'(1));

  // channel offset as shifted adds of the stride
  assign ch_off  = (ch_q[0] ? ag.chstride : '0) +
                   (ch_q[1] ? (ag.chstride << 1) : '0) +
                   (ch_q[2] ? (ag.chstride << 2) : '0);

  // saturating gradient add
  always_comb begin
    gsum = (VW + 1)'($signed(g_rdata)) + (VW + 1)'(coef_q);
    if (gsum > (VW + 1)'(signed'({1'b0, {(VW - 1){1'b1}}}))) begin
      gsat = {1'b0, {(VW - 1){1'b1}}};
    end else if (gsum < (VW + 1)'(signed'({2'b11, {(VW - 1){1'b0}}}))) begin
      gsat = {1'b1, {(VW - 1){1'b0}}};
    end else begin
      gsat = gsum[VW-1:0];
    end
  end

  // controller
  always_comb begin
    state_d    = state_q;
    emitting_d = emitting_q;
    clr_d      = clr_q;
    cur_d      = cur_q;
    o_d        = o_q;
    adv        = 1'b0;
    w_we       = 1'b0;
    g_we       = 1'b0;
    w_addr     = idx;
    g_addr     = idx;
    w_wdata    = wv_q;
    g_wdata    = '0;
    emit       = 1'b0;
    ev_val     = '0;
    ev_ch      = '0;
    ev_last    = 1'b1;
    ev_ovf     = !inr;
    case (state_q)
      S_CLEAR: begin
        w_we    = 1'b1;
        g_we    = 1'b1;
        w_addr  = clr_q;
        g_addr  = clr_q;
        w_wdata = '0;
        clr_d   = clr_q + MW'(1);
        if (clr_q == MW'(STORE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        // evaluation results leave from here, one channel per cycle
        if (emitting_q) begin
          emit    = 1'b1;
          ev_val  = sum_q[o_q];
          ev_ch   = 3'(o_q);
          ev_last = last_ch;
          ev_ovf  = ovf_q[o_q];
          o_d     = o_q + OW'(1);
          if (last_ch) begin
            emitting_d = 1'b0;
          end
        end else if (accept) begin
          cur_d = AW'(entry_addr_i);
          o_d   = '0;
          case (ctcu_pkg::req_e'(req_type_i))
            ctcu_pkg::REQ_WRITE:     state_d = S_WRITE;
            ctcu_pkg::REQ_READCLEAR: state_d = S_RC_RD;
            default:                 state_d = S_WAIT;
          endcase
        end
      end
      S_WRITE: begin
        w_we    = inr;
        emit    = 1'b1;
        state_d = S_IDLE;
      end
      S_RC_RD: begin
        state_d = S_RC_WB;
      end
      S_RC_WB: begin
        g_we    = inr;
        emit    = 1'b1;
        ev_val  = inr ? g_rdata : '0;
        state_d = S_IDLE;
      end
      S_WAIT: begin
        if (ag.valid) begin
          if (req_q == ctcu_pkg::REQ_ACCUM) begin
            cur_d   = ag.addr + ch_off;
            state_d = S_ACC_RD;
          end else begin
            cur_d   = ag.addr;
            o_d     = '0;
            state_d = S_EV_RD;
          end
        end
      end
      S_ACC_RD: begin
        if (inr) begin
          state_d = S_ACC_WB;
        end else begin
          adv = 1'b1;
          if (ag.last) begin
            emit    = 1'b1;
            ev_ch   = ch_q;
            ev_ovf  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_WAIT;
          end
        end
      end
      S_ACC_WB: begin
        g_we    = 1'b1;
        g_wdata = gsat;
        adv     = 1'b1;
        if (ag.last) begin
          emit    = 1'b1;
          ev_ch   = ch_q;
          ev_ovf  = aovf_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_WAIT;
        end
      end
      S_EV_RD, S_EV_SUM: begin
        if ((state_q == S_EV_RD) && inr) begin
          state_d = S_EV_SUM;
        end else if (last_ch) begin
          // all channels of this tiling done
          adv = 1'b1;
          o_d = '0;
          if (ag.last) begin
            emitting_d = 1'b1;
            state_d    = S_IDLE;
          end else begin
            state_d = S_WAIT;
          end
        end else begin
          o_d     = o_q + OW'(1);
          cur_d   = cur_q + ag.chstride;
          state_d = S_EV_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_CLEAR;
      emitting_q      <= 1'b0;
      clr_q           <= '0;
      result_strobe_o <= 1'b0;
    end else begin
      state_q         <= state_d;
      emitting_q      <= emitting_d;
      clr_q           <= clr_d;
      result_strobe_o <= emit;
    end
  end

  // request latch, sums and result word
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    o_q   <= o_d;
    if (accept) begin
      req_q  <= ctcu_pkg::req_e'(req_type_i);
      ch_q   <= channel_select_i;
      coef_q <= coefficient_i;
      wv_q   <= weight_value_i;
      aovf_q <= 1'b0;
      for (int d = 0; d < MAX_DIMS; d++) begin
        coord_q[d] <= coord_all[d];
      end
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        sum_q[k] <= '0;
        ovf_q[k] <= 1'b0;
      end
    end
    if ((state_q == S_ACC_RD) && !inr) begin
      aovf_q <= 1'b1;
    end
    if ((state_q == S_EV_RD) && !inr) begin
      ovf_q[o_q] <= 1'b1;
    end
    if (state_q == S_EV_SUM) begin
      sum_q[o_q] <= sum_q[o_q] + VW'($signed(w_rdata));
    end
    if (emit) begin
      result_value_o   <= ev_val;
      result_channel_o <= ev_ch;
      last_result_o    <= ev_last;
      addr_overflow_o  <= ev_ovf;
    end
  end

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("block not busy after accepting a word");

  // a final result is never directly followed by another
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_result_o |=> !result_strobe_o)
    else $error("result right after a final result");

  // single results always carry the last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && (req_q != ctcu_pkg::REQ_EVAL) |-> last_result_o)
    else $error("single result without last flag");

  // no memory write while waiting for a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !w_we && !g_we)
    else $error("memory write while idle");

  // address generator is only advanced when it holds an address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |-> ag.valid)
    else $error("address generator advanced without an address");

endmodule

>>> src/ctcu_store.sv
// ----------------------------------------------------------------------------
// ctcu_store
// Weight and gradient memories, one port each, registered read data.
// ----------------------------------------------------------------------------
module ctcu_store #(
  parameter int STORE_DEPTH = ctcu_pkg::STORE_DEPTH_C,
  localparam int MW = $clog2(STORE_DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       w_we_i,
  input  logic [MW-1:0]              w_addr_i,
  input  logic [15:0]                w_wdata_i,
  output logic [15:0]                w_rdata_o,
  input  logic                       g_we_i,
  input  logic [MW-1:0]              g_addr_i,
  input  logic [ctcu_pkg::VAL_W-1:0] g_wdata_i,
  output logic [ctcu_pkg::VAL_W-1:0] g_rdata_o
);

  logic [15:0]                w_mem [STORE_DEPTH];
  logic [ctcu_pkg::VAL_W-1:0] g_mem [STORE_DEPTH];

  // weight memory
  always_ff @(posedge clk_i) begin
    if (w_we_i) begin
      w_mem[w_addr_i] <= w_wdata_i;
    end
    w_rdata_o <= w_mem[w_addr_i];
  end

  // gradient memory
  always_ff @(posedge clk_i) begin
    if (g_we_i) begin
      g_mem[g_addr_i] <= g_wdata_i;
    end
    g_rdata_o <= g_mem[g_addr_i];
  end

endmodule

>>> src/ctcu_addr_gen.sv
// ----------------------------------------------------------------------------
// ctcu_addr_gen
// Quantizes the input point for one tiling at a time and forms the channel 0
// address of that tiling, plus the channel stride.
// ----------------------------------------------------------------------------
module ctcu_addr_gen #(
  parameter int MAX_DIMS    = ctcu_pkg::MAX_DIMS_C,
  parameter int MAX_TILINGS = ctcu_pkg::MAX_TILINGS_C,
  localparam int TLW = $clog2(MAX_TILINGS + 1),
  localparam int DCW = $clog2(MAX_DIMS + 1),
  localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1,
  localparam int TW  = (MAX_TILINGS > 1) ? $clog2(MAX_TILINGS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic               adv_i,
  input  logic signed [15:0] coord_i [MAX_DIMS],
  input  logic signed [15:0] lower_i,
  input  logic [15:0]        inv_i,
  input  logic [6:0]         tiles_i,
  input  logic [TLW-1:0]     tilings_i,
  input  logic [DCW-1:0]     dims_i,
  output ctcu_pkg::ag_t      ag_o
);

  localparam int AW = ctcu_pkg::ADDR_W;
  // cells in one tiling: up to 64 ** MAX_DIMS
  localparam int PW = 6 * MAX_DIMS + 1;

  typedef enum logic [5:0] {
    A_IDLE   = 6'b000001,
    A_DIV    = 6'b000010,
    A_STRIDE = 6'b000100,
    A_MUL    = 6'b001000,
    A_ACC    = 6'b010000,
    A_READY  = 6'b100000
  } ag_state_e;

  ag_state_e         state_q, state_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [7:0]        rem_q, rem_d;
  logic [15:0]       quo_q, quo_d;
  logic [PW-1:0]     p_q, p_d;
  logic [DCW-1:0]    pcnt_q, pcnt_d;
  logic [AW-1:0]     chstride_q, chstride_d;
  logic [15:0]       off_q, off_d;
  logic [7:0]        r_q, r_d;
  logic [AW-1:0]     tbase_q, tbase_d;
  logic [TW-1:0]     t_q, t_d;
  logic [DW-1:0]     d_q, d_d;
  logic [PW-1:0]     acc_q, acc_d;
  logic signed [33:0] prod_q, prod_d;
  logic [AW-1:0]     addr_q, addr_d;

  logic [7:0]        rem_sh;
  logic signed [16:0] diff;
  logic signed [16:0] inv_s;
  logic [34:0]       v;
  logic [18:0]       vs;
  logic [6:0]        tmax;
  logic [6:0]        tile_num;
  logic [PW-1:0]     acc_n;
  logic [PW+6:0]     cs;
  logic [7:0]        r_sum;
  logic              last_t;

  assign last_t = (t_q == TW'(tilings_i - TLW'(1)));
  assign tmax   = tiles_i - 7'd1;

  // long division of 2**15 by the tiling count, one bit per cycle
  assign rem_sh = {rem_q[6:0], (cnt_q == 4'd15)};

  // distance from the lower bound, and the scale as a signed operand
  assign diff  = 17'(coord_i[d_q]) - 17'(lower_i);
  assign inv_s = {1'b0, inv_i};

  // tile number along the current dimension, clamped to the grid
  always_comb begin
    v        = {prod_q[33], prod_q} + {19'b0, off_q};
    vs       = v[34:16];
    tile_num = '0;
    if (!v[34] && (v != '0)) begin
      tile_num = (vs > 19'(tmax)) ? tmax : vs[6:0];
    end
  end

  assign acc_n = acc_q * PW'(tiles_i) + PW'(tile_num);
  assign cs    = {7'b0, p_q} * (PW + 7)'(tilings_i);
  assign r_sum = r_q + rem_q;

  // sequencer
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    p_d        = p_q;
    pcnt_d     = pcnt_q;
    chstride_d = chstride_q;
    off_d      = off_q;
    r_d        = r_q;
    tbase_d    = tbase_q;
    t_d        = t_q;
    d_d        = d_q;
    acc_d      = acc_q;
    prod_d     = prod_q;
    addr_d     = addr_q;
    case (state_q)
      A_IDLE: begin
        if (go_i) begin
          cnt_d   = 4'd15;
          rem_d   = '0;
          quo_d   = '0;
          p_d     = PW'(1);
          pcnt_d  = '0;
          state_d = A_DIV;
        end
      end
      A_DIV: begin
        if (rem_sh >= 8'(tilings_i)) begin
          rem_d = rem_sh - 8'(tilings_i);
          quo_d = {quo_q[14:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quo_d = {quo_q[14:0], 1'b0};
        end
        // cells per tiling, built alongside
        if (pcnt_q < dims_i) begin
          p_d    = p_q * PW'(tiles_i);
          pcnt_d = pcnt_q + DCW'(1);
        end
        cnt_d = cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          state_d = A_STRIDE;
        end
      end
      A_STRIDE: begin
        chstride_d = AW'(cs);
        off_d      = quo_q;
        r_d        = rem_q;
        tbase_d    = '0;
        t_d        = '0;
        d_d        = DW'(dims_i - DCW'(1));
        acc_d      = '0;
        state_d    = A_MUL;
      end
      A_MUL: begin
        prod_d  = diff * inv_s;
        state_d = A_ACC;
      end
      A_ACC: begin
        acc_d = acc_n;
        if (d_q == '0) begin
          addr_d  = tbase_q + AW'(acc_n);
          state_d = A_READY;
        end else begin
          d_d     = d_q - DW'(1);
          state_d = A_MUL;
        end
      end
      A_READY: begin
        if (adv_i) begin
          if (last_t) begin
            state_d = A_IDLE;
          end else begin
            t_d     = t_q + TW'(1);
            tbase_d = tbase_q + AW'(p_q);
            if (r_sum >= 8'(tilings_i)) begin
              r_d   = r_sum - 8'(tilings_i);
              off_d = off_q + quo_q + 16'd1;
            end else begin
              r_d   = r_sum;
              off_d = off_q + quo_q;
            end
            acc_d   = '0;
            d_d     = DW'(dims_i - DCW'(1));
            state_d = A_MUL;
          end
        end
      end
      default: state_d = A_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cnt_q      <= cnt_d;
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    p_q        <= p_d;
    pcnt_q     <= pcnt_d;
    chstride_q <= chstride_d;
    off_q      <= off_d;
    r_q        <= r_d;
    tbase_q    <= tbase_d;
    t_q        <= t_d;
    d_q        <= d_d;
    acc_q      <= acc_d;
    prod_q     <= prod_d;
    addr_q     <= addr_d;
  end

  assign ag_o.valid    = (state_q == A_READY);
  assign ag_o.last     = last_t;
  assign ag_o.addr     = addr_q;
  assign ag_o.chstride = chstride_q;

endmodule

>>> bench/tb_cmac_tile_coding_unit.sv
// ----------------------------------------------------------------------------
// tb_cmac_tile_coding_unit
// Self-checking bench for the CMAC tile coding unit. A behavioral model of
// the quantizer, the address generator and both memories predicts every
// result word. Directed tests cover register extremes and each request kind,
// then random traffic runs under several register settings with random gaps.
// ----------------------------------------------------------------------------
module tb_cmac_tile_coding_unit;

  localparam int DEPTH = ctcu_pkg::STORE_DEPTH_C;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic signed [23:0] value;
    logic [2:0]         channel;
    logic               last;
    logic               ovf;
  } result_word_t;

  typedef struct {
    ctcu_pkg::req_e     kind;
    logic signed [15:0] coord [ctcu_pkg::NUM_COORDS];
    logic [2:0]         channel;
    logic signed [15:0] coeff;
    logic [11:0]        addr;
    logic signed [15:0] weight;
  } request_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic start = 1'b0;
  logic [1:0] req_type_i = '0;
  logic signed [15:0] coord_0_i = '0, coord_1_i = '0, coord_2_i = '0, coord_3_i = '0;
  logic [2:0] channel_select_i = '0;
  logic signed [15:0] coefficient_i = '0;
  logic [11:0] entry_addr_i = '0;
  logic signed [15:0] weight_value_i = '0;
  logic cfg_ready_o, busy, result_strobe_o, last_result_o, addr_overflow_o;
  logic signed [23:0] result_value_o;
  logic [2:0] result_channel_o;

  // model state
  logic signed [15:0] weight_mem [DEPTH];
  logic signed [23:0] grad_mem [DEPTH];
  logic signed [15:0] m_lower;
  logic [15:0] m_inv;
  logic [6:0]  m_tiles;
  logic [4:0]  m_tiling_count;
  logic [2:0]  m_dims;
  logic [3:0]  m_outputs;

  result_word_t expected_words[$];
  bit failed = 1'b0;
  int idle_cycles = 0;
  bit accepted_now;

  always #5 clk_i = ~clk_i;

  cmac_tile_coding_unit i_dut (.*);

  // count cycles without any accepted word or result word
  always @(posedge clk_i) begin
    accepted_now = result_strobe_o || (start && !busy) || (cfg_valid_i && cfg_ready_o);
    if (accepted_now) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    result_word_t exp_w;
    if (rst_ni && result_strobe_o) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word value=%0d", result_value_o);
        failed = 1'b1;
      end else begin
        exp_w = expected_words.pop_front();
        if (result_value_o !== exp_w.value) begin
          $error("result_value exp %0d got %0d", exp_w.value, result_value_o);
          failed = 1'b1;
        end
        if (result_channel_o !== exp_w.channel) begin
          $error("result_channel exp %0d got %0d", exp_w.channel, result_channel_o);
          failed = 1'b1;
        end
        if (last_result_o !== exp_w.last) begin
          $error("last_result exp %0d got %0d", exp_w.last, last_result_o);
          failed = 1'b1;
        end
        if (addr_overflow_o !== exp_w.ovf) begin
          $error("addr_overflow exp %0d got %0d", exp_w.ovf, addr_overflow_o);
          failed = 1'b1;
        end
      end
    end
  end

  // tiling base addresses for one point; returns the channel stride
  function automatic longint tile_bases(request_t r,
                                        output longint base [ctcu_pkg::MAX_TILINGS_C],
                                        output int ntil);
    longint tiles, per_tiling, off, v, tile_idx, a, stride;
    int tl, dims;
    tiles = (m_tiles < 2) ? 2 : (m_tiles > 64) ? 64 : m_tiles;
    tl = (m_tiling_count < 1) ? 1 :
         (m_tiling_count > ctcu_pkg::MAX_TILINGS_C) ? ctcu_pkg::MAX_TILINGS_C :
         m_tiling_count;
    dims = (m_dims < 1) ? 1 : (m_dims > ctcu_pkg::MAX_DIMS_C) ? ctcu_pkg::MAX_DIMS_C : m_dims;
    per_tiling = 1;
    for (int d = 0; d < dims; d++) per_tiling *= tiles;
    for (int t = 0; t < tl; t++) begin
      off = ((t + 1) * 32768) / tl;
      a = t * per_tiling;
      stride = 1;
      for (int d = 0; d < dims; d++) begin
        v = (longint'(r.coord[d]) - longint'(m_lower)) * longint'(m_inv) + off;
        tile_idx = 0;
        if (v > 0) begin
          tile_idx = v >>> 16;
          if (tile_idx > tiles - 1) tile_idx = tiles - 1;
        end
        a += tile_idx * stride;
        stride *= tiles;
      end
      base[t] = a;
    end
    ntil = tl;
    return per_tiling * tl;
  endfunction

  // update the memories and queue the result words of one request
  task automatic predict_request(request_t r);
    longint base [ctcu_pkg::MAX_TILINGS_C];
    longint chs, a, s;
    int ntil, nout;
    bit ovf;
    case (r.kind)
      ctcu_pkg::REQ_WRITE: begin
        weight_mem[r.addr] = r.weight;
        expected_words.push_back('{0, 0, 1'b1, 1'b0});
      end
      ctcu_pkg::REQ_READCLEAR: begin
        expected_words.push_back('{grad_mem[r.addr], 0, 1'b1, 1'b0});
        grad_mem[r.addr] = '0;
      end
      ctcu_pkg::REQ_ACCUM: begin
        chs = tile_bases(r, base, ntil);
        ovf = 1'b0;
        for (int t = 0; t < ntil; t++) begin
          a = base[t] + longint'(r.channel) * chs;
          if (a >= DEPTH) ovf = 1'b1;
          else begin
            s = longint'(grad_mem[a]) + longint'(r.coeff);
            if (s > 8388607) s = 8388607;
            if (s < -8388608) s = -8388608;
            grad_mem[a] = s[23:0];
          end
        end
        expected_words.push_back('{0, r.channel, 1'b1, ovf});
      end
      default: begin
        chs = tile_bases(r, base, ntil);
        nout = (m_outputs < 1) ? 1 :
               (m_outputs > ctcu_pkg::MAX_OUTPUTS_C) ? ctcu_pkg::MAX_OUTPUTS_C : m_outputs;
        for (int o = 0; o < nout; o++) begin
          s = 0;
          ovf = 1'b0;
          for (int t = 0; t < ntil; t++) begin
            a = base[t] + o * chs;
            if (a >= DEPTH) ovf = 1'b1;
            else s += longint'(weight_mem[a]);
          end
          expected_words.push_back('{s[23:0], o[2:0], (o + 1 == nout), ovf});
        end
      end
    endcase
  endtask

  // random gap, mostly short and now and then long; start drops only in a gap
  task automatic random_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) :
        ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // send one request word and predict its results
  task automatic send_request(request_t r, bit gaps = 1'b1);
    if (gaps) random_gap();
    req_type_i <= r.kind;
    coord_0_i <= r.coord[0];
    coord_1_i <= r.coord[1];
    coord_2_i <= r.coord[2];
    coord_3_i <= r.coord[3];
    channel_select_i <= r.channel;
    coefficient_i <= r.coeff;
    entry_addr_i <= r.addr;
    weight_value_i <= r.weight;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    predict_request(r);
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  task automatic write_register(ctcu_pkg::cfg_idx_e idx, logic [15:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ctcu_pkg::CFG_LOWER:   m_lower = data;
      ctcu_pkg::CFG_INV:     m_inv = data;
      ctcu_pkg::CFG_TILES:   m_tiles = data[6:0];
      ctcu_pkg::CFG_TILINGS: m_tiling_count = data[4:0];
      ctcu_pkg::CFG_DIMS:    m_dims = data[2:0];
      default:               m_outputs = data[3:0];
    endcase
  endtask

  task automatic set_geometry(logic [15:0] lo, logic [15:0] inv, int tiles, int tl,
                              int dims, int outs);
    drain();
    write_register(ctcu_pkg::CFG_LOWER, lo);
    write_register(ctcu_pkg::CFG_INV, inv);
    write_register(ctcu_pkg::CFG_TILES, 16'(tiles));
    write_register(ctcu_pkg::CFG_TILINGS, 16'(tl));
    write_register(ctcu_pkg::CFG_DIMS, 16'(dims));
    write_register(ctcu_pkg::CFG_OUTPUTS, 16'(outs));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic request_t random_request(ctcu_pkg::req_e kind, bit extreme);
    request_t r;
    r.kind = kind;
    for (int d = 0; d < ctcu_pkg::NUM_COORDS; d++)
      r.coord[d] = extreme ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000) :
                   ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                   16'($urandom_range(0, 16'h0a00));
    r.channel = 3'($urandom());
    r.coeff = 16'($urandom());
    if ($urandom_range(0, 4) == 0) r.coeff = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    r.addr = $urandom_range(0, 1) ? 12'($urandom_range(0, 255)) : 12'($urandom());
    r.weight = 16'($urandom());
    return r;
  endfunction

  // directed: every request kind, field and register extremes
  task automatic test_directed();
    request_t r;
    r = random_request(ctcu_pkg::REQ_WRITE, 1'b0);
    r.addr = 12'd0; r.weight = 16'h7fff; send_request(r);
    r.addr = 12'hfff; r.weight = 16'h8000; send_request(r);
    r.addr = 12'd5; r.weight = 16'hffff; send_request(r);
    for (int i = 0; i < 4; i++) send_request(random_request(ctcu_pkg::REQ_EVAL, i[0]));
    r = random_request(ctcu_pkg::REQ_ACCUM, 1'b0);
    r.coeff = 16'h7fff; r.channel = 3'd0; send_request(r);
    r.channel = 3'd7; send_request(r);
    send_request(random_request(ctcu_pkg::REQ_ACCUM, 1'b1));
    r = random_request(ctcu_pkg::REQ_READCLEAR, 1'b0);
    r.addr = 12'd0; send_request(r);
    r.addr = 12'hfff; send_request(r);
    // repeated adds to one gradient entry, one tile hit repeatedly
    set_geometry(16'd0, 16'd0, 2, 1, 1, 8);
    r = random_request(ctcu_pkg::REQ_ACCUM, 1'b0);
    r.channel = 3'd0;
    r.coeff = 16'h7fff;
    repeat (4) send_request(r, 1'b0);
    r.coeff = 16'h8000;
    repeat (2) send_request(r, 1'b0);
    send_request(random_request(ctcu_pkg::REQ_EVAL, 1'b0));
    // largest geometry overflows the store
    set_geometry(16'h8000, 16'hffff, 64, 16, 4, 8);
    send_request(random_request(ctcu_pkg::REQ_EVAL, 1'b0));
    send_request(random_request(ctcu_pkg::REQ_ACCUM, 1'b1));
    // out-of-range register values act as clamped
    set_geometry(16'h7fff, 16'h0100, 0, 0, 0, 0);
    send_request(random_request(ctcu_pkg::REQ_EVAL, 1'b0));
    set_geometry(16'h0000, 16'h0100, 127, 31, 7, 15);
    send_request(random_request(ctcu_pkg::REQ_EVAL, 1'b0));
  endtask

  // random traffic in one register setting
  task automatic test_random_phase(int count);
    request_t r;
    for (int i = 0; i < count; i++) begin
      r = random_request(ctcu_pkg::req_e'($urandom_range(0, 3)), $urandom_range(0, 9) == 0);
      if (r.kind == ctcu_pkg::REQ_READCLEAR && $urandom_range(0, 1))
        r.addr = 12'($urandom_range(0, 63));
      send_request(r);
    end
  endtask

  task automatic test_random();
    set_geometry(16'h0000, 16'h0100, 4, 4, 2, 2);
    test_random_phase(60);
    set_geometry(16'hff00, 16'h0200, 8, 3, 3, 3);
    test_random_phase(60);
    set_geometry(16'h0000, 16'($urandom()), 2, 16, 1, 8);
    test_random_phase(50);
    set_geometry(16'($urandom()), 16'($urandom()), $urandom_range(2, 16),
                 $urandom_range(1, 16), $urandom_range(1, 4), $urandom_range(1, 8));
    test_random_phase(50);
    set_geometry(16'h0000, 16'h0080, 6, 2, 4, 1);
    test_random_phase(40);
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      weight_mem[i] = '0;
      grad_mem[i] = '0;
    end
    m_lower = 16'sd0; m_inv = 16'd256; m_tiles = 7'd8;
    m_tiling_count = 5'd4; m_dims = 3'd2; m_outputs = 4'd1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random();
    drain();
    if (!failed) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> cmac_tile_coding_unit.f
src/ctcu_pkg.sv
src/ctcu_store.sv
src/ctcu_addr_gen.sv
src/cmac_tile_coding_unit.sv
bench/tb_cmac_tile_coding_unit.sv
